@@ hdl/rcmr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmr_pkg
// Shared types, constants and helpers of the remote control median receiver.
// ----------------------------------------------------------------------------
package rcmr_pkg;

    localparam int AXIS_COUNT   = 2;
    localparam int BUTTON_COUNT = 8;

    localparam logic [7:0] AXIS_RAW_MAX = 8'd200;
    localparam logic [7:0] AXIS_CENTER  = 8'd100;

    // configuration register indexes
    localparam logic [1:0] REG_START_VALUE   = 2'd0;
    localparam logic [1:0] REG_SILENCE_LIMIT = 2'd1;

    localparam logic [15:0] SILENCE_LIMIT_RST = 16'd100;
    localparam logic [15:0] SILENCE_MAX       = 16'hFFFF;

    // top level sequencer
    typedef enum logic [1:0] {
        T_IDLE,
        T_UPDATE,
        T_MEDIAN,
        T_DONE
    } top_state_t;

    // median sweep sequencer
    typedef enum logic [1:0] {
        M_IDLE,
        M_LOAD,
        M_CMP
    } med_state_t;

    // history write request from the top level
    typedef struct packed {
        logic             wr_en;
        logic             clr;
        logic             left_ok;
        logic             right_ok;
        logic signed [7:0] left_val;
        logic signed [7:0] right_val;
        logic [7:0]       buttons;
    } hist_wr_t;

    // median unit status
    typedef struct packed {
        logic              done;
        logic signed [7:0] left;
        logic signed [7:0] right;
    } med_status_t;

    // button k of a byte is pressed when bit 7-2k is 1 and bit 6-2k is 0
    function automatic logic [3:0] decode_pairs(input logic [7:0] b);
        logic [3:0] r;
        for (int k = 0; k < 4; k++)
        begin
            r[k] = b[7 - 2 * k] & ~b[6 - 2 * k];
        end
        return r;
    endfunction

endpackage

@@ hdl/rcmr_history.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmr_history
// Ring of axis and button samples with one read port and button voting.
// ----------------------------------------------------------------------------
module rcmr_history
    import rcmr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    localparam int IDX_W = $clog2(HISTORY_DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  hist_wr_t            wr,
    input  logic                rd_axis,
    input  logic [IDX_W-1:0]    rd_idx,
    output logic signed [7:0]   rd_data,
    output logic [BUTTON_COUNT-1:0] btn_vote
);

    logic signed [7:0] axis_reg [AXIS_COUNT][HISTORY_DEPTH];
    logic [BUTTON_COUNT-1:0] btn_reg [HISTORY_DEPTH];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;

    // ring head wraps at the depth
    always_comb
    begin
        head_next = head_reg;
        if (wr.wr_en)
        begin
            if (head_reg == IDX_W'(HISTORY_DEPTH - 1))
                head_next = '0;
            else
                head_next = head_reg + 1'b1;
        end
    end

    // sample store, cleared on reset and on loss of link
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                axis_reg[0][i] <= '0;
                axis_reg[1][i] <= '0;
                btn_reg[i]     <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            if (wr.clr)
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    axis_reg[0][i] <= '0;
                    axis_reg[1][i] <= '0;
                    btn_reg[i]     <= '0;
                end
            end
            else if (wr.wr_en)
            begin
                if (wr.left_ok)
                    axis_reg[0][head_reg] <= wr.left_val;
                if (wr.right_ok)
                    axis_reg[1][head_reg] <= wr.right_val;
                btn_reg[head_reg] <= wr.buttons;
            end
        end
    end

    // single read port for the median sweep
    assign rd_data = axis_reg[rd_axis][rd_idx];

    // majority vote per button
    always_comb
    begin
        logic [IDX_W:0] n;
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            n = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                n = n + {{IDX_W{1'b0}}, btn_reg[i][b]};
            end
            btn_vote[b] = ({n, 1'b0} > (IDX_W + 2)'(HISTORY_DEPTH));
        end
    end

endmodule

@@ hdl/rcmr_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmr_median
// Serial median of both axis histories with one shared compare unit.
// ----------------------------------------------------------------------------
module rcmr_median
    import rcmr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    localparam int IDX_W = $clog2(HISTORY_DEPTH),
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               rd_axis,
    output logic [IDX_W-1:0]   rd_idx,
    input  logic signed [7:0]  rd_data,
    output med_status_t        status
);

    med_state_t state_reg, state_next;
    logic axis_reg, axis_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic signed [7:0] v_reg, v_next;
    logic [CNT_W-1:0] hi_reg, hi_next, lo_reg, lo_next, same_reg, same_next;
    logic found_reg, found_next;
    logic signed [7:0] left_reg, left_next, right_reg, right_next;
    logic done_reg, done_next;

    // shared compare unit and median test
    logic [CNT_W-1:0] hi_c, lo_c, same_c, spread;
    logic hit;
    logic row_last, col_last;

    always_comb
    begin
        hi_c   = hi_reg   + CNT_W'(v_reg < rd_data);
        lo_c   = lo_reg   + CNT_W'(v_reg > rd_data);
        same_c = same_reg + CNT_W'(v_reg == rd_data);
        spread = (hi_c >= lo_c) ? (hi_c - lo_c) : (lo_c - hi_c);
        hit    = spread < same_c;
    end

    assign row_last = (row_reg == IDX_W'(HISTORY_DEPTH - 1));
    assign col_last = (col_reg == IDX_W'(HISTORY_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
                if (start)
                    state_next = M_LOAD;
            M_LOAD:
                state_next = M_CMP;
            M_CMP:
                if (col_last)
                    state_next = (row_last && axis_reg) ? M_IDLE : M_LOAD;
            default:
                state_next = M_IDLE;
        endcase
    end

    // sweep datapath
    always_comb
    begin
        axis_next  = axis_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        v_next     = v_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        same_next  = same_reg;
        found_next = found_reg;
        left_next  = left_reg;
        right_next = right_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
                if (start)
                begin
                    axis_next  = 1'b0;
                    row_next   = '0;
                    found_next = 1'b0;
                    left_next  = '0;
                    right_next = '0;
                end
            M_LOAD:
            begin
                v_next    = rd_data;
                col_next  = '0;
                hi_next   = '0;
                lo_next   = '0;
                same_next = '0;
            end
            M_CMP:
            begin
                hi_next   = hi_c;
                lo_next   = lo_c;
                same_next = same_c;
                col_next  = col_reg + 1'b1;
                if (col_last)
                begin
                    // first row that passes the test gives the median
                    if (hit && !found_reg)
                    begin
                        found_next = 1'b1;
                        if (axis_reg)
                            right_next = v_reg;
                        else
                            left_next = v_reg;
                    end
                    if (row_last)
                    begin
                        row_next   = '0;
                        axis_next  = 1'b1;
                        found_next = 1'b0;
                        done_next  = axis_reg;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            axis_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            axis_reg  <= axis_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        same_reg  <= same_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // read address: candidate row on load, compared column otherwise
    assign rd_axis = axis_reg;
    assign rd_idx  = (state_reg == M_LOAD) ? row_reg : col_reg;

    assign status.done  = done_reg;
    assign status.left  = left_reg;
    assign status.right = right_reg;

endmodule

@@ hdl/remote_control_median_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_control_median_receiver
// Filters polled remote control messages into median axes and voted buttons.
// ----------------------------------------------------------------------------
// Usage
//   s_* takes one poll per item: s_tuser flags a present message, s_tdata
//   carries its five bytes. m_* gives one result per poll: both axis medians
//   and the button votes in m_tdata, changed and disabled flags in m_tuser.
//   cfg_we/cfg_index/cfg_data write start value (index 0) and silence limit
//   (index 1) while the block is idle, a user rule the block does not check.
// Timing
//   For a matching message the median sweep lies between acceptance and a
//   valid result; it reads one history entry per cycle into a single
//   comparator. Other polls skip the sweep. One item is worked on at a time;
//   s_tready is low from acceptance until the result is loaded into the
//   output register.
// Reset
//   Histories, current values, silence count and flags clear; the start
//   value becomes 0 and the silence limit 100.
// Stall
//   A result holds in the output register while m_tready is low; the next
//   item may be accepted meanwhile, and its result waits until the register
//   frees.
// ----------------------------------------------------------------------------
module remote_control_median_receiver
    import rcmr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // poll items
    input  logic        s_tvalid,
    output logic        s_tready,
    // lead_byte, left_axis_raw, right_axis_raw, face_buttons_byte,
    // shoulder_buttons_byte
    input  logic [39:0] s_tdata,
    // message_ready
    input  logic        s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_axis, right_axis, button_states
    output logic [23:0] m_tdata,
    // values_changed, link_disabled
    output logic [1:0]  m_tuser
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    top_state_t state_reg, state_next;

    // configuration registers
    logic [7:0]  start_value_reg;
    logic [15:0] silence_limit_reg;

    // captured poll
    logic       ready_reg;
    logic [7:0] lead_reg, left_raw_reg, right_raw_reg, face_reg, shoulder_reg;

    // link and published state
    logic [15:0] silence_reg, silence_next;
    logic        seen_reg, seen_next;
    logic        disabled_reg, disabled_next;
    logic signed [7:0] cur_left_reg, cur_left_next, cur_right_reg, cur_right_next;
    logic [7:0]  cur_btn_reg, cur_btn_next;
    logic        changed_reg, changed_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;

    hist_wr_t    hist_wr;
    med_status_t med_st;
    logic        med_start;
    logic        rd_axis;
    logic [IDX_W-1:0] rd_idx;
    logic signed [7:0] rd_data;
    logic [BUTTON_COUNT-1:0] btn_vote;

    logic        active, msg_ok;
    logic [15:0] silence_inc;
    logic        out_free;

    rcmr_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (hist_wr),
        .rd_axis  (rd_axis),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data),
        .btn_vote (btn_vote)
    );

    rcmr_median #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (med_start),
        .rd_axis (rd_axis),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .status  (med_st)
    );

    // poll classification
    assign active      = !disabled_reg && (seen_reg || ready_reg);
    assign msg_ok      = active && ready_reg && (lead_reg == start_value_reg);
    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 16'd1;
    assign out_free    = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
                if (s_tvalid)
                    state_next = T_UPDATE;
            T_UPDATE:
                state_next = msg_ok ? T_MEDIAN : T_DONE;
            T_MEDIAN:
                if (med_st.done)
                    state_next = T_DONE;
            T_DONE:
                if (out_free)
                    state_next = T_IDLE;
            default:
                state_next = T_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready          = (state_reg == T_IDLE);
        med_start         = (state_reg == T_UPDATE) && msg_ok;
        hist_wr.wr_en     = (state_reg == T_UPDATE) && msg_ok;
        hist_wr.clr       = (state_reg == T_UPDATE) && active && !ready_reg
                            && (silence_inc > silence_limit_reg);
        hist_wr.left_ok   = (left_raw_reg <= AXIS_RAW_MAX);
        hist_wr.right_ok  = (right_raw_reg <= AXIS_RAW_MAX);
        hist_wr.left_val  = left_raw_reg - AXIS_CENTER;
        hist_wr.right_val = right_raw_reg - AXIS_CENTER;
        hist_wr.buttons   = {decode_pairs(shoulder_reg), decode_pairs(face_reg)};
    end

    // link state and published values
    always_comb
    begin
        silence_next   = silence_reg;
        seen_next      = seen_reg;
        disabled_next  = disabled_reg;
        cur_left_next  = cur_left_reg;
        cur_right_next = cur_right_reg;
        cur_btn_next   = cur_btn_reg;
        changed_next   = changed_reg;
        unique case (state_reg)
            T_UPDATE:
            begin
                changed_next = 1'b0;
                if (active)
                begin
                    seen_next = 1'b1;
                    if (msg_ok)
                        silence_next = '0;
                    else if (!ready_reg)
                    begin
                        silence_next = silence_inc;
                        if (silence_inc > silence_limit_reg)
                            disabled_next = 1'b1;
                    end
                end
            end
            T_MEDIAN:
                if (med_st.done)
                begin
                    cur_left_next  = med_st.left;
                    cur_right_next = med_st.right;
                    cur_btn_next   = btn_vote;
                    changed_next   = (med_st.left != cur_left_reg)
                                     || (med_st.right != cur_right_reg)
                                     || (btn_vote != cur_btn_reg);
                end
            T_IDLE, T_DONE:
                changed_next = changed_reg;
            default:
                changed_next = changed_reg;
        endcase
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if ((state_reg == T_DONE) && out_free)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {cur_btn_reg, cur_right_reg, cur_left_reg};
            m_user_next  = {disabled_reg, changed_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            start_value_reg   <= '0;
            silence_limit_reg <= SILENCE_LIMIT_RST;
            silence_reg       <= '0;
            seen_reg          <= 1'b0;
            disabled_reg      <= 1'b0;
            cur_left_reg      <= '0;
            cur_right_reg     <= '0;
            cur_btn_reg       <= '0;
            changed_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            silence_reg   <= silence_next;
            seen_reg      <= seen_next;
            disabled_reg  <= disabled_next;
            cur_left_reg  <= cur_left_next;
            cur_right_reg <= cur_right_next;
            cur_btn_reg   <= cur_btn_next;
            changed_reg   <= changed_next;
            m_valid_reg   <= m_valid_next;
            // configuration writes
            if (cfg_we)
            begin
                if (cfg_index == REG_START_VALUE)
                    start_value_reg <= cfg_data[7:0];
                else if (cfg_index == REG_SILENCE_LIMIT)
                    silence_limit_reg <= cfg_data;
            end
        end
    end

    // captured item and output payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ready_reg     <= s_tuser;
            lead_reg      <= s_tdata[7:0];
            left_raw_reg  <= s_tdata[15:8];
            right_raw_reg <= s_tdata[23:16];
            face_reg      <= s_tdata[31:24];
            shoulder_reg  <= s_tdata[39:32];
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    // link loss is sticky
    a_disabled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        disabled_reg |=> disabled_reg)
        else $error("disabled flag dropped");

    // median results arrive only while waiting for them
    a_median_done: assert property (@(posedge clk) disable iff (!rst_n)
        med_st.done |-> (state_reg == T_MEDIAN))
        else $error("median done outside median wait");

    // no history write once disabled
    a_no_write_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        hist_wr.wr_en |-> !disabled_reg)
        else $error("history written while link disabled");

endmodule
